// File: sv/psc_pkg.sv
// Package for the pressure sensor compensation block.
// Holds operation codes, register indexes, datapath constants and the
// request/response types of the shared serial arithmetic unit.
`default_nettype none

package psc_pkg;

   // operation codes of an input transaction
   localparam logic [1:0] OP_TEMPERATURE = 2'd0;
   localparam logic [1:0] OP_PRESSURE    = 2'd1;
   localparam logic [1:0] OP_ALTITUDE    = 2'd2;

   // configuration register indexes
   localparam logic [2:0] REG_AC1     = 3'd0;
   localparam logic [2:0] REG_AC2     = 3'd1;
   localparam logic [2:0] REG_AC3     = 3'd2;
   localparam logic [2:0] REG_AC4     = 3'd3;
   localparam logic [2:0] REG_AC5_AC6 = 3'd4;
   localparam logic [2:0] REG_B1_B2   = 3'd5;
   localparam logic [2:0] REG_MC_MD   = 3'd6;
   localparam logic [2:0] REG_OSS     = 3'd7;

   // field widths
   localparam int OP_W   = 2;
   localparam int RAW_W  = 19;
   localparam int RES_W  = 32;
   localparam int CSR_W  = 32;
   localparam int IDX_W  = 3;

   // serial unit widths
   localparam int ACC_W  = 64;   // product width
   localparam int MPL_W  = 33;   // multiplier operand, two's complement
   localparam int DVD_W  = 44;   // dividend width
   localparam int DVS_W  = 32;   // divisor width
   localparam int CNT_W  = 6;

   // reset values of the calibration registers
   localparam logic [15:0] RST_AC1     = 16'd408;
   localparam logic [15:0] RST_AC2     = 16'hFFB8;
   localparam logic [15:0] RST_AC3     = 16'hC7D1;
   localparam logic [15:0] RST_AC4     = 16'd32741;
   localparam logic [31:0] RST_AC5_AC6 = 32'd2146785905;
   localparam logic [31:0] RST_B1_B2   = 32'd405667844;
   localparam logic [31:0] RST_MC_MD   = 32'd3724086068;
   localparam logic [1:0]  RST_OSS     = 2'd3;

   // datapath constants
   localparam logic [31:0] C_B6_OFFSET = 32'd4000;
   localparam logic [31:0] C_B4_OFFSET = 32'd32768;
   localparam logic [15:0] C_B7_SCALE  = 16'd50000;
   localparam logic [32:0] C_P_MUL1    = 33'd3038;
   localparam logic [32:0] C_P_MUL2    = -33'sd7375;
   localparam logic [31:0] C_P_OFFSET  = 32'd3791;
   localparam logic [63:0] C_SEA_LEVEL = 64'd101325;
   localparam logic [32:0] C_ALT_MUL   = 33'd843;
   localparam logic [31:0] C_ALT_DIV   = 32'd10000;

   // request to the serial unit
   typedef struct packed {
      logic               start;
      logic               is_div;
      logic [ACC_W-1:0]   opa;    // multiplicand, or dividend in the low bits
      logic [MPL_W-1:0]   opb;    // multiplier, or divisor in the low bits
   } alu_req_type;

   // response of the serial unit
   typedef struct packed {
      logic               done;
      logic [ACC_W-1:0]   value;  // product, or quotient in the low bits
   } alu_rsp_type;

endpackage

`default_nettype wire

// File: sv/psc_serial_alu.sv
// Shared bit-serial multiply and divide unit of the compensation block.
// One multiplier bit or one quotient bit per cycle; uses psc_pkg.
`default_nettype none

module psc_serial_alu (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire psc_pkg::alu_req_type req,
   output psc_pkg::alu_rsp_type     rsp
);
   import psc_pkg::*;

   localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(MPL_W - 1);
   localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(DVD_W - 1);

   logic               busy_ff;
   logic               done_ff;
   logic               div_ff;
   logic [CNT_W-1:0]   cnt_ff;
   logic [ACC_W-1:0]   acc_ff;
   logic [ACC_W-1:0]   mcand_ff;
   logic [MPL_W-1:0]   mplier_ff;
   logic [DVS_W:0]     rem_ff;
   logic [DVD_W-1:0]   quo_ff;
   logic [DVS_W-1:0]   divisor_ff;

   logic [ACC_W-1:0]   addend;
   logic [ACC_W-1:0]   acc_in;
   logic [DVS_W:0]     shifted;
   logic [DVS_W+1:0]   diff;
   logic               ge;
   logic [DVS_W:0]     rem_in;
   logic [DVD_W-1:0]   quo_in;
   logic               last;

   // one multiply step: top multiplier bit carries negative weight
   always_comb begin
      if (!mplier_ff[0]) begin
         addend = '0;
      end else if (cnt_ff == MUL_LAST) begin
         addend = -mcand_ff;
      end else begin
         addend = mcand_ff;
      end
      acc_in = acc_ff + addend;
   end

   // one restoring divide step
   always_comb begin
      shifted = {rem_ff[DVS_W-1:0], quo_ff[DVD_W-1]};
      diff    = {1'b0, shifted} - {2'b00, divisor_ff};
      ge      = ~diff[DVS_W+1];
      rem_in  = ge ? diff[DVS_W:0] : shifted;
      quo_in  = {quo_ff[DVD_W-2:0], ge};
      last    = div_ff ? (cnt_ff == DIV_LAST) : (cnt_ff == MUL_LAST);
   end

   // sequencing and datapath registers
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (req.start && !busy_ff) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (last) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req.start && !busy_ff) begin
         div_ff     <= req.is_div;
         acc_ff     <= '0;
         mcand_ff   <= req.opa;
         mplier_ff  <= req.opb;
         rem_ff     <= '0;
         quo_ff     <= req.opa[DVD_W-1:0];
         divisor_ff <= req.opb[DVS_W-1:0];
      end else if (busy_ff) begin
         if (div_ff) begin
            rem_ff <= rem_in;
            quo_ff <= quo_in;
         end else begin
            acc_ff    <= acc_in;
            mcand_ff  <= {mcand_ff[ACC_W-2:0], 1'b0};
            mplier_ff <= {1'b0, mplier_ff[MPL_W-1:1]};
         end
      end
   end

   assign rsp.done  = done_ff;
   assign rsp.value = div_ff ? {{(ACC_W-DVD_W){1'b0}}, quo_ff} : acc_ff;

endmodule

`default_nettype wire

// File: sv/pressure_sensor_compensation.sv
// Top level of the barometric sensor integer compensation block.
// Sequencer, calibration registers and output register; uses psc_pkg
// and the shared serial unit psc_serial_alu.
//
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+----------------------------------
//  req_     | in        | req_valid/stall    | req_operation, req_raw_value
//  rsp_     | out       | rsp_valid/stall    | rsp_result_value, rsp_divide_fault
//  csr_     | in        | csr_write_enable   | csr_index, csr_write_data
//
// One transaction at a time, each operation in the shared serial unit:
// temperature takes one multiply and one divide, pressure ten multiplies and
// one divide, altitude the pressure steps plus one multiply and one divide, then
// the output register; a zero divisor ends the transaction early.
// Synchronous reset restores the calibration reset values and clears B5.
// A new transaction is taken while a finished result is still held by rsp_stall.
`default_nettype none

module pressure_sensor_compensation (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_stall,
   input  wire logic [psc_pkg::OP_W-1:0]    req_operation,
   input  wire logic [psc_pkg::RAW_W-1:0]   req_raw_value,
   output logic                             rsp_valid,
   input  wire logic                        rsp_stall,
   output logic signed [psc_pkg::RES_W-1:0] rsp_result_value,
   output logic                             rsp_divide_fault,
   input  wire logic                        csr_write_enable,
   input  wire logic [psc_pkg::IDX_W-1:0]   csr_index,
   input  wire logic [psc_pkg::CSR_W-1:0]   csr_write_data
);
   import psc_pkg::*;

   typedef enum logic [4:0] {
      S_IDLE, S_T0, S_T1,
      S_P0, S_P1, S_P2, S_P3, S_P4, S_P5, S_P6, S_P7, S_P8, S_P9, S_P10,
      S_A0, S_A1, S_OUT
   } state_type;

   state_type        state_ff;
   logic             wait_ff;

   logic [15:0]      ac1_ff, ac2_ff, ac3_ff, ac4_ff;
   logic [31:0]      ac56_ff, b12_ff, mcmd_ff;
   logic [1:0]       oss_ff;

   logic [OP_W-1:0]  op_ff;
   logic [RAW_W-1:0] raw_ff;
   logic [31:0]      temp_ff;
   logic [31:0]      ra_ff, sq_ff, b3_ff, b7_ff, p_ff, dv_ff;
   logic [16:0]      b4_ff;
   logic [DVD_W-1:0] mag_ff;
   logic             neg_ff;
   logic [31:0]      res_ff;
   logic             fault_ff;

   logic             rsp_valid_ff;
   logic [31:0]      rsp_value_ff;
   logic             rsp_fault_ff;

   alu_req_type      alu_req;
   alu_rsp_type      alu_rsp;

   logic [15:0]      ac5, ac6, b1, b2, mc, md, mcmag;
   logic [31:0]      b6;
   logic [19:0]      tdiff;
   logic [ACC_W-1:0] prod;
   logic             computing;

   // derived calibration fields
   always_comb begin
      ac5   = ac56_ff[31:16];
      ac6   = ac56_ff[15:0];
      b1    = b12_ff[31:16];
      b2    = b12_ff[15:0];
      mc    = mcmd_ff[31:16];
      md    = mcmd_ff[15:0];
      mcmag = mc[15] ? 16'(-mc) : mc;
      b6    = temp_ff - C_B6_OFFSET;
      tdiff = {1'b0, raw_ff} - {4'b0000, ac6};
      prod  = alu_rsp.value;
   end

   assign computing = (state_ff != S_IDLE) && (state_ff != S_OUT);

   // operand selection for the serial unit
   always_comb begin
      alu_req.start  = computing && !wait_ff;
      alu_req.is_div = 1'b0;
      alu_req.opa    = '0;
      alu_req.opb    = '0;
      unique case (state_ff)
         S_T0: begin
            alu_req.opa = {{44{tdiff[19]}}, tdiff};
            alu_req.opb = {17'd0, ac5};
         end
         S_T1: begin
            alu_req.is_div = 1'b1;
            alu_req.opa    = {37'd0, mcmag, 11'd0};
            alu_req.opb    = {1'b0, dv_ff};
         end
         S_P0: begin
            alu_req.opa = {{32{b6[31]}}, b6};
            alu_req.opb = {b6[31], b6};
         end
         S_P1: begin
            alu_req.opa = {{32{sq_ff[31]}}, sq_ff};
            alu_req.opb = {{17{b2[15]}}, b2};
         end
         S_P2: begin
            alu_req.opa = {{32{b6[31]}}, b6};
            alu_req.opb = {{17{ac2_ff[15]}}, ac2_ff};
         end
         S_P3: begin
            alu_req.opa = {{32{b6[31]}}, b6};
            alu_req.opb = {{17{ac3_ff[15]}}, ac3_ff};
         end
         S_P4: begin
            alu_req.opa = {{32{sq_ff[31]}}, sq_ff};
            alu_req.opb = {{17{b1[15]}}, b1};
         end
         S_P5: begin
            alu_req.opa = {32'd0, ra_ff};
            alu_req.opb = {17'd0, ac4_ff};
         end
         S_P6: begin
            alu_req.opa = {32'd0, {13'd0, raw_ff} - b3_ff};
            alu_req.opb = {17'd0, C_B7_SCALE >> oss_ff};
         end
         S_P7: begin
            alu_req.is_div = 1'b1;
            alu_req.opa    = {32'd0, b7_ff[31] ? b7_ff : {b7_ff[30:0], 1'b0}};
            alu_req.opb    = {16'd0, b4_ff};
         end
         S_P8: begin
            alu_req.opa = {{40{p_ff[31]}}, p_ff[31:8]};
            alu_req.opb = {{9{p_ff[31]}}, p_ff[31:8]};
         end
         S_P9: begin
            alu_req.opa = {{32{ra_ff[31]}}, ra_ff};
            alu_req.opb = C_P_MUL1;
         end
         S_P10: begin
            alu_req.opa = {{32{p_ff[31]}}, p_ff};
            alu_req.opb = C_P_MUL2;
         end
         S_A0: begin
            alu_req.opa = C_SEA_LEVEL - {{32{p_ff[31]}}, p_ff};
            alu_req.opb = C_ALT_MUL;
         end
         S_A1: begin
            alu_req.is_div = 1'b1;
            alu_req.opa    = {20'd0, mag_ff};
            alu_req.opb    = {1'b0, C_ALT_DIV};
         end
         default: begin
         end
      endcase
   end

   psc_serial_alu u_alu (
      .clock (clock),
      .reset (reset),
      .req   (alu_req),
      .rsp   (alu_rsp)
   );

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         ac1_ff  <= RST_AC1;
         ac2_ff  <= RST_AC2;
         ac3_ff  <= RST_AC3;
         ac4_ff  <= RST_AC4;
         ac56_ff <= RST_AC5_AC6;
         b12_ff  <= RST_B1_B2;
         mcmd_ff <= RST_MC_MD;
         oss_ff  <= RST_OSS;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            REG_AC1:     ac1_ff  <= csr_write_data[15:0];
            REG_AC2:     ac2_ff  <= csr_write_data[15:0];
            REG_AC3:     ac3_ff  <= csr_write_data[15:0];
            REG_AC4:     ac4_ff  <= csr_write_data[15:0];
            REG_AC5_AC6: ac56_ff <= csr_write_data;
            REG_B1_B2:   b12_ff  <= csr_write_data;
            REG_MC_MD:   mcmd_ff <= csr_write_data;
            REG_OSS:     oss_ff  <= csr_write_data[1:0];
            default:     ;
         endcase
      end
   end

   // sequencer, working registers and output register
   always_ff @(posedge clock) begin : seq
      logic [31:0] x1, den, q, b5, x3, t, p2, sm;
      logic [32:0] s33;
      logic [33:0] s34;
      logic [63:0] m;
      if (reset) begin
         state_ff     <= S_IDLE;
         wait_ff      <= 1'b0;
         temp_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // output drained, nothing new to load this cycle
         if (rsp_valid_ff && !rsp_stall && state_ff != S_OUT) begin
            rsp_valid_ff <= 1'b0;
         end
         if (alu_req.start) begin
            wait_ff <= 1'b1;
         end
         if (alu_rsp.done) begin
            wait_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  op_ff    <= req_operation;
                  raw_ff   <= req_raw_value;
                  res_ff   <= '0;
                  fault_ff <= 1'b0;
                  case (req_operation) inside
                     OP_TEMPERATURE:            state_ff <= S_T0;
                     OP_PRESSURE, OP_ALTITUDE:  state_ff <= S_P0;
                     default:                   state_ff <= S_OUT;
                  endcase
               end
            end
            S_T0: if (alu_rsp.done) begin
               x1  = prod[46:15];
               den = x1 + {{16{md[15]}}, md};
               if (den == '0) begin
                  fault_ff <= 1'b1;
                  state_ff <= S_OUT;
               end else begin
                  ra_ff    <= x1;
                  neg_ff   <= mc[15] ^ den[31];
                  dv_ff    <= den[31] ? -den : den;
                  state_ff <= S_T1;
               end
            end
            S_T1: if (alu_rsp.done) begin
               q        = prod[31:0];
               b5       = ra_ff + (neg_ff ? -q : q);
               s33      = {b5[31], b5} + 33'd8;
               temp_ff  <= b5;
               res_ff   <= {{3{s33[32]}}, s33[32:4]};
               state_ff <= S_OUT;
            end
            S_P0: if (alu_rsp.done) begin
               sq_ff    <= prod[43:12];
               state_ff <= S_P1;
            end
            S_P1: if (alu_rsp.done) begin
               ra_ff    <= prod[42:11];
               state_ff <= S_P2;
            end
            S_P2: if (alu_rsp.done) begin
               x3 = ra_ff + prod[42:11];
               t  = {{14{ac1_ff[15]}}, ac1_ff, 2'b00} + x3;
               t  = (t << oss_ff) + 32'd2;
               t  = t + {30'd0, t[31], t[31]};
               b3_ff    <= {{2{t[31]}}, t[31:2]};
               state_ff <= S_P3;
            end
            S_P3: if (alu_rsp.done) begin
               ra_ff    <= prod[44:13];
               state_ff <= S_P4;
            end
            S_P4: if (alu_rsp.done) begin
               s34 = {{2{ra_ff[31]}}, ra_ff} + {{2{prod[47]}}, prod[47:16]} + 34'd2;
               ra_ff    <= s34[33:2] + C_B4_OFFSET;
               state_ff <= S_P5;
            end
            S_P5: if (alu_rsp.done) begin
               if (prod[31:15] == '0) begin
                  fault_ff <= 1'b1;
                  state_ff <= S_OUT;
               end else begin
                  b4_ff    <= prod[31:15];
                  state_ff <= S_P6;
               end
            end
            S_P6: if (alu_rsp.done) begin
               b7_ff    <= prod[31:0];
               state_ff <= S_P7;
            end
            S_P7: if (alu_rsp.done) begin
               p_ff     <= b7_ff[31] ? {prod[30:0], 1'b0} : prod[31:0];
               state_ff <= S_P8;
            end
            S_P8: if (alu_rsp.done) begin
               ra_ff    <= prod[31:0];
               state_ff <= S_P9;
            end
            S_P9: if (alu_rsp.done) begin
               ra_ff    <= prod[47:16];
               state_ff <= S_P10;
            end
            S_P10: if (alu_rsp.done) begin
               sm = ra_ff + prod[47:16] + C_P_OFFSET;
               p2 = p_ff + {{4{sm[31]}}, sm[31:4]};
               if (op_ff == OP_PRESSURE) begin
                  res_ff   <= p2;
                  state_ff <= S_OUT;
               end else begin
                  p_ff     <= p2;
                  state_ff <= S_A0;
               end
            end
            S_A0: if (alu_rsp.done) begin
               m = prod[63] ? -prod : prod;
               neg_ff   <= prod[63];
               mag_ff   <= m[DVD_W-1:0];
               state_ff <= S_A1;
            end
            S_A1: if (alu_rsp.done) begin
               q        = prod[31:0];
               res_ff   <= neg_ff ? -q : q;
               state_ff <= S_OUT;
            end
            S_OUT: begin
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_value_ff <= res_ff;
                  rsp_fault_ff <= fault_ff;
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_stall        = (state_ff != S_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_value = rsp_value_ff;
   assign rsp_divide_fault = rsp_fault_ff;

   // the serial unit only reports after an issued operation
   a_done_waited: assert property (@(posedge clock) disable iff (reset)
      alu_rsp.done |-> wait_ff)
      else $error("serial unit done without an issued operation");

   // a fault always carries a zero result
   a_fault_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (!rsp_divide_fault || rsp_result_value == '0))
      else $error("fault with non-zero result");

   // an accepted transaction leaves idle
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> state_ff != S_IDLE)
      else $error("accepted transaction not started");

   // a result appears only out of the output state
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_OUT))
      else $error("result raised outside the output state");

endmodule

`default_nettype wire

// File: tb/tb_top.sv
// Self-checking testbench for pressure_sensor_compensation.
// Drives temperature, pressure and altitude transactions under random idling,
// predicts every response in a local integer model; depends on psc_pkg.
`default_nettype none

module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import psc_pkg::*;

   localparam int CYCLE_LIMIT = 6000000;
   localparam int DRAIN_CYCLES = 600;
   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

   typedef struct {
      logic [OP_W-1:0]  op;
      logic [RAW_W-1:0] raw;
   } reading_type;

   typedef struct {
      logic [RES_W-1:0] value;
      logic             fault;
   } comp_result_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_stall;
   logic [OP_W-1:0]         req_operation = '0;
   logic [RAW_W-1:0]        req_raw_value = '0;
   logic                    rsp_valid;
   logic                    rsp_stall = 1'b0;
   logic signed [RES_W-1:0] rsp_result_value;
   logic                    rsp_divide_fault;
   logic                    csr_write_enable = 1'b0;
   logic [IDX_W-1:0]        csr_index = '0;
   logic [CSR_W-1:0]        csr_write_data = '0;

   pressure_sensor_compensation uut (.*);

   // local copy of calibration and stored b5
   logic [31:0]  cal [8];
   longint       b5_store;

   reading_type     pending_readings [$];
   comp_result_type expected_results [$];
   int           error_count = 0;
   int           results_seen = 0;
   int           cycle_count = 0;
   bit           quiet = 1'b0;
   bit           req_fired = 1'b0;
   int           req_gap = 0;
   int           rsp_gap = 0;
   int           hold_request = 0;
   int           hold_left = 0;
   int           op_counts [4] = '{0, 0, 0, 0};
   int           fault_count = 0;

   // clock
   initial begin
      forever #1 clock = ~clock;
   end

   function automatic longint wrap32(longint x);
      return longint'(int'(x));
   endfunction

   function automatic longint sext16(logic [15:0] v);
      return longint'(shortint'(v));
   endfunction

   // pressure from raw reading; returns 0 when b4 is zero
   function automatic bit compute_pressure(logic [RAW_W-1:0] up, output longint p);
      logic [1:0]  oss;
      longint      ac1, ac2, ac3, b1, b2, b6, sq, x1, x2, x3, b3;
      logic [31:0] ac4, t, b4, d, b7, q;
      logic [63:0] m;
      oss = cal[REG_OSS][1:0];
      ac1 = sext16(cal[REG_AC1][15:0]);
      ac2 = sext16(cal[REG_AC2][15:0]);
      ac3 = sext16(cal[REG_AC3][15:0]);
      ac4 = {16'b0, cal[REG_AC4][15:0]};
      b1 = sext16(cal[REG_B1_B2][31:16]);
      b2 = sext16(cal[REG_B1_B2][15:0]);
      b6 = wrap32(b5_store - 4000);
      sq = wrap32((b6 * b6) >>> 12);
      x1 = wrap32((b2 * sq) >>> 11);
      x2 = wrap32((ac2 * b6) >>> 11);
      x3 = wrap32(x1 + x2);
      b3 = wrap32(wrap32(wrap32(ac1 * 4 + x3) * (longint'(1) << oss)) + 2);
      b3 = wrap32(b3 / 4);
      x1 = wrap32((ac3 * b6) >>> 13);
      x2 = wrap32((b1 * sq) >>> 16);
      x3 = wrap32((x1 + x2 + 2) >>> 2);
      t = 32'(x3 + 32768);
      m = {32'b0, ac4} * {32'b0, t};
      b4 = m[31:0] >> 15;
      d = {13'b0, up} - 32'(b3);
      m = {32'b0, d} * {32'b0, (32'd50000 >> oss)};
      b7 = m[31:0];
      p = 0;
      if (b4 == 0) return 1'b0;
      if (b7 < 32'h8000_0000) q = (b7 * 32'd2) / b4;
      else q = (b7 / b4) * 32'd2;
      p = wrap32(longint'(q));
      x1 = p >>> 8;
      x1 = wrap32(x1 * x1);
      x1 = wrap32((x1 * 3038) >>> 16);
      x2 = wrap32((-7375 * p) >>> 16);
      p = wrap32(p + (wrap32(x1 + x2 + 3791) >>> 4));
      return 1'b1;
   endfunction

   // expected response of one reading; updates stored b5
   function automatic comp_result_type compensate(reading_type r);
      comp_result_type res;
      longint ac5, ac6, mc, md, x1, x2, den, b5, p;
      res.value = '0;
      res.fault = 1'b0;
      case (r.op) inside
         OP_TEMPERATURE: begin
            ac5 = longint'(cal[REG_AC5_AC6][31:16]);
            ac6 = longint'(cal[REG_AC5_AC6][15:0]);
            mc = sext16(cal[REG_MC_MD][31:16]);
            md = sext16(cal[REG_MC_MD][15:0]);
            x1 = wrap32(((longint'(r.raw) - ac6) * ac5) >>> 15);
            den = wrap32(x1 + md);
            if (den == 0) begin
               res.fault = 1'b1;
            end else begin
               x2 = wrap32((mc * 2048) / den);
               b5 = wrap32(x1 + x2);
               b5_store = b5;
               res.value = 32'((b5 + 8) >>> 4);
            end
         end
         OP_PRESSURE, OP_ALTITUDE: begin
            if (!compute_pressure(r.raw, p)) res.fault = 1'b1;
            else if (r.op == OP_PRESSURE) res.value = 32'(p);
            else res.value = 32'(((101325 - p) * 843) / 10000);
         end
         default: ;
      endcase
      return res;
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      error_count++;
      $display("MISMATCH %s: got %0d (0x%08h) expected %0d (0x%08h) at cycle %0d",
               what, $signed(got), got, $signed(want), want, cycle_count);
   endtask

   // input driver: sample acceptance at rising edge, drive at falling edge
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) begin
         reading_type r;
         r.op = req_operation;
         r.raw = req_raw_value;
         expected_results.push_back(compensate(r));
         req_fired = 1'b1;
      end
   end

   always @(negedge clock) begin
      reading_type r;
      logic next_valid;
      next_valid = req_valid;
      if (!reset && (!req_valid || req_fired)) begin
         req_fired = 1'b0;
         next_valid = 1'b0;
         if (req_gap > 0) begin
            req_gap--;
         end else if (pending_readings.size() > 0) begin
            if (!quiet && $urandom_range(0, 5) == 0) begin
               req_gap = $urandom_range(0, 3);
            end else begin
               r = pending_readings.pop_front();
               req_operation <= r.op;
               req_raw_value <= r.raw;
               next_valid = 1'b1;
            end
         end
      end
      req_valid <= next_valid;
   end

   // long receiver hold-off, counted here
   always @(negedge clock) begin
      if (hold_request > 0) begin
         hold_left = hold_request;
         hold_request = 0;
      end else if (hold_left > 0) begin
         hold_left--;
      end
   end

   // receiver stall bursts
   always @(negedge clock) begin
      logic s;
      s = 1'b0;
      if (rsp_gap > 0) begin
         rsp_gap--;
         s = 1'b1;
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
         rsp_gap = $urandom_range(0, 3);
         s = 1'b1;
      end
      rsp_stall <= s || (hold_left > 0) || (hold_request > 0);
   end

   // response monitor and cycle limit
   always @(posedge clock) begin
      comp_result_type e;
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles", cycle_count);
         $display("Test completed with failures");
         $finish;
      end else if (!reset && rsp_valid && !rsp_stall) begin
         results_seen++;
         if (expected_results.size() == 0) begin
            report_mismatch("unexpected response", rsp_result_value, '0);
         end else begin
            e = expected_results.pop_front();
            if (rsp_result_value !== e.value)
               report_mismatch("result_value", rsp_result_value, e.value);
            if (rsp_divide_fault !== e.fault)
               report_mismatch("divide_fault", {31'b0, rsp_divide_fault}, {31'b0, e.fault});
            if (e.fault) fault_count++;
         end
      end
   end

   task automatic write_reg(logic [IDX_W-1:0] idx, logic [31:0] data);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= data;
      case (idx) inside
         REG_AC1, REG_AC2, REG_AC3, REG_AC4: cal[idx] = {16'b0, data[15:0]};
         REG_OSS: cal[idx] = {30'b0, data[1:0]};
         default: cal[idx] = data;
      endcase
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic add_reading(logic [OP_W-1:0] op, logic [RAW_W-1:0] raw);
      reading_type r;
      r.op = op;
      r.raw = raw;
      pending_readings.push_back(r);
      op_counts[op]++;
   endtask

   // wait until every queued transaction is accepted and answered
   task automatic wait_idle();
      while (pending_readings.size() > 0 || req_valid || expected_results.size() > 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   function automatic logic [31:0] cal_value(int kind);
      case (kind)
         0: return 32'h0000_0000;
         1: return 32'hFFFF_FFFF;
         2: return 32'h8000_8000;
         3: return 32'h7FFF_7FFF;
         default: return $urandom;
      endcase
   endfunction

   // random calibration with extremes mixed in
   task automatic randomise_cal(bit realistic);
      if (realistic) begin
         write_reg(REG_AC1, 32'($urandom_range(0, 9000)));
         write_reg(REG_AC2, 32'(-$signed(32'($urandom_range(0, 1500)))));
         write_reg(REG_AC3, 32'(-$signed(32'($urandom_range(10000, 16000)))));
         write_reg(REG_AC4, 32'($urandom_range(30000, 36000)));
         write_reg(REG_AC5_AC6, {16'($urandom_range(20000, 35000)),
                                 16'($urandom_range(15000, 25000))});
         write_reg(REG_B1_B2, {16'($urandom_range(5000, 7000)), 16'($urandom_range(0, 200))});
         write_reg(REG_MC_MD, {16'(-$signed(32'($urandom_range(8000, 12000)))),
                               16'($urandom_range(2000, 3000))});
      end else begin
         for (int i = 0; i < 7; i++)
            write_reg(i[IDX_W-1:0], cal_value($urandom_range(0, 7)));
      end
      write_reg(REG_OSS, 32'($urandom_range(0, 3)));
   endtask

   task automatic random_readings(int count);
      logic [OP_W-1:0]  op;
      logic [RAW_W-1:0] raw;
      for (int i = 0; i < count; i++) begin
         op = ($urandom_range(0, 19) == 0) ? OP_UNUSED : OP_W'($urandom_range(0, 2));
         case ($urandom_range(0, 2))
            0: raw = RAW_W'($urandom_range(0, 524287));
            1: raw = (op == OP_TEMPERATURE) ? RAW_W'($urandom_range(20000, 35000))
                                            : RAW_W'($urandom_range(20000, 400000));
            default: raw = RAW_W'($urandom_range(0, 65535));
         endcase
         add_reading(op, raw);
      end
   endtask

   // stimulus sequence
   initial begin
      for (int i = 0; i < 8; i++) cal[i] = '0;
      cal[REG_AC1] = {16'b0, RST_AC1};
      cal[REG_AC2] = {16'b0, RST_AC2};
      cal[REG_AC3] = {16'b0, RST_AC3};
      cal[REG_AC4] = {16'b0, RST_AC4};
      cal[REG_AC5_AC6] = RST_AC5_AC6;
      cal[REG_B1_B2] = RST_B1_B2;
      cal[REG_MC_MD] = RST_MC_MD;
      cal[REG_OSS] = {30'b0, RST_OSS};
      b5_store = 0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: pressure before temperature, extremes, unused code
      add_reading(OP_PRESSURE, 19'd23843);
      add_reading(OP_ALTITUDE, 19'd23843);
      add_reading(OP_TEMPERATURE, 19'd27898);
      add_reading(OP_PRESSURE, 19'd23843);
      add_reading(OP_ALTITUDE, 19'd23843);
      add_reading(OP_TEMPERATURE, 19'd0);
      add_reading(OP_TEMPERATURE, 19'd65535);
      add_reading(OP_TEMPERATURE, 19'h7FFFF);
      add_reading(OP_PRESSURE, 19'd0);
      add_reading(OP_PRESSURE, 19'h7FFFF);
      add_reading(OP_ALTITUDE, 19'h7FFFF);
      add_reading(OP_UNUSED, 19'h7FFFF);
      add_reading(OP_UNUSED, 19'd0);
      add_reading(OP_TEMPERATURE, 19'd27898);
      wait_idle();

      // oversampling extremes with realistic data
      write_reg(REG_OSS, 32'd0);
      add_reading(OP_PRESSURE, 19'd23843);
      add_reading(OP_ALTITUDE, 19'd100000);
      wait_idle();

      // zero divisors on both paths; stored b5 must survive a faulted temperature
      write_reg(REG_AC5_AC6, 32'h0000_1234);
      write_reg(REG_MC_MD, 32'h8000_0000);
      write_reg(REG_AC4, 32'd0);
      add_reading(OP_TEMPERATURE, 19'd27898);
      add_reading(OP_PRESSURE, 19'd23843);
      add_reading(OP_ALTITUDE, 19'h7FFFF);
      wait_idle();
      write_reg(REG_OSS, 32'hFFFF_FFFF);

      // random phases, one with a long receiver hold-off
      for (int ph = 0; ph < 8; ph++) begin
         randomise_cal(ph % 2 == 0);
         quiet = (ph == 7);
         if (ph == 2) hold_request = 1500;
         random_readings(ph == 7 ? 130 : 160);
         wait_idle();
      end

      // drain
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Covered %0d temperature, %0d pressure, %0d altitude, %0d unused-code items",
               op_counts[0], op_counts[1], op_counts[2], op_counts[3]);
      $display("%0d responses checked, %0d with divide fault, across 11 calibration settings",
               results_seen, fault_count);
      if (error_count == 0 && expected_results.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

`default_nettype wire
